>>> hw/rtl/hbp_pkg.sv
package hbp_pkg;

	localparam int SEGMENTS = 8;

	localparam int AMT_W  = 24;
	localparam int SUM_W  = 25;
	localparam int CNT_W  = 6;
	localparam int OCLS_W = 5;
	localparam int CLS_W  = $clog2(SEGMENTS);
	localparam int WGT_W  = $clog2(SEGMENTS + 1);
	localparam int PROD_W = AMT_W + WGT_W;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [1:0] REG_LIMIT     = 2'd0;
	localparam logic [1:0] REG_BASE_CPU  = 2'd1;
	localparam logic [1:0] REG_BASE_MEM  = 2'd2;

	typedef struct packed {
		logic [SUM_W-1:0] cpu;
		logic [SUM_W-1:0] mem;
		logic [CNT_W-1:0] count;
	} cell_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

>>> hw/rtl/hbp_cell.sv
module hbp_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hbp_pkg::cell_ctl_t            ctl,
	input  hbp_pkg::cell_t                load_data,
	input  hbp_pkg::cell_t                neighbor,
	input  logic [hbp_pkg::WGT_W-1:0]     weight,
	input  logic [hbp_pkg::AMT_W-1:0]     limit,
	input  logic [hbp_pkg::PROD_W-1:0]    scaled_cpu,
	output hbp_pkg::cell_t                state,
	output logic                          below
);

	hbp_pkg::cell_t state_q;
	logic [hbp_pkg::PROD_W-1:0] bound;

	// Upper bound of this cell's size class: limit times (class index plus one).
	assign bound = hbp_pkg::PROD_W'(limit) * hbp_pkg::PROD_W'(weight);
	assign below = scaled_cpu < bound;
	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (ctl.shift) begin
			state_q <= neighbor;
		end else if (ctl.load) begin
			state_q <= load_data;
		end
	end

endmodule

>>> hw/rtl/hbp_update.sv
module hbp_update (
	input  hbp_pkg::cell_t                cur,
	input  logic [hbp_pkg::CLS_W-1:0]     cls,
	input  logic [hbp_pkg::AMT_W-1:0]     cpu,
	input  logic [hbp_pkg::AMT_W-1:0]     mem,
	input  logic [hbp_pkg::AMT_W-1:0]     limit,
	input  logic [hbp_pkg::AMT_W-1:0]     base_cpu,
	input  logic [hbp_pkg::AMT_W-1:0]     base_mem,
	output hbp_pkg::cell_t                next,
	output logic                          emit
);

	logic [hbp_pkg::SUM_W-1:0] cur_cpu, cur_mem;
	logic [hbp_pkg::SUM_W:0]   add_cpu, add_mem, open_cpu, open_mem;
	logic [hbp_pkg::CNT_W-1:0] cap;
	logic                      occupied, over, fits;

	function automatic logic [hbp_pkg::SUM_W-1:0] sat(input logic [hbp_pkg::SUM_W:0] v);
		sat = v[hbp_pkg::SUM_W] ? hbp_pkg::SUM_MAX : v[hbp_pkg::SUM_W-1:0];
	endfunction

	always_comb begin
		occupied = cur.count != '0;
		// An empty class is treated as holding the current base amounts.
		cur_cpu  = occupied ? cur.cpu : hbp_pkg::SUM_W'(base_cpu);
		cur_mem  = occupied ? cur.mem : hbp_pkg::SUM_W'(base_mem);
		add_cpu  = (hbp_pkg::SUM_W+1)'(cur_cpu) + (hbp_pkg::SUM_W+1)'(cpu);
		add_mem  = (hbp_pkg::SUM_W+1)'(cur_mem) + (hbp_pkg::SUM_W+1)'(mem);
		open_cpu = (hbp_pkg::SUM_W+1)'(base_cpu) + (hbp_pkg::SUM_W+1)'(cpu);
		open_mem = (hbp_pkg::SUM_W+1)'(base_mem) + (hbp_pkg::SUM_W+1)'(mem);
		over     = (add_cpu > (hbp_pkg::SUM_W+1)'(limit)) ||
		           (add_mem > (hbp_pkg::SUM_W+1)'(limit));
		cap      = hbp_pkg::CNT_W'(hbp_pkg::SEGMENTS) - hbp_pkg::CNT_W'(cls);
		fits     = !over && (cur.count < cap);
		if (fits) begin
			next.cpu   = sat(add_cpu);
			next.mem   = sat(add_mem);
			next.count = cur.count + hbp_pkg::CNT_W'(1);
		end else begin
			next.cpu   = sat(open_cpu);
			next.mem   = sat(open_mem);
			next.count = hbp_pkg::CNT_W'(1);
		end
		emit = !fits && occupied;
	end

endmodule

>>> hw/rtl/harmonic_bin_packer.sv
// Add beat: the request is classified, then the class cell is updated; any bin it closes is
// registered at the end of the update, and the next beat is taken once the state is idle again.
// Flush beat: the row of class cells shifts toward the output one position per cycle, once
// per size class, unless an output stall holds it; output stalls also hold an add beat's update.
// One beat is in work at a time; the next is taken once the current one retires.
// Reset (arst_n low, asynchronous) empties every class and loads the register defaults.
module harmonic_bin_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          command,
	input  logic [hbp_pkg::AMT_W-1:0]     cpu_amount,
	input  logic [hbp_pkg::AMT_W-1:0]     memory_amount,
	output logic                          bin_valid,
	input  logic                          bin_stall,
	output logic [hbp_pkg::SUM_W-1:0]     bin_cpu,
	output logic [hbp_pkg::SUM_W-1:0]     bin_memory,
	output logic [hbp_pkg::CNT_W-1:0]     bin_items,
	output logic [hbp_pkg::OCLS_W-1:0]    bin_class,
	output logic                          last_of_run,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [hbp_pkg::AMT_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_CLASSIFY = 2'd1;
	localparam logic [1:0] ST_UPDATE   = 2'd2;
	localparam logic [1:0] ST_FLUSH    = 2'd3;

	logic [1:0]                    state_q, state_d;
	logic [hbp_pkg::AMT_W-1:0]     limit_q, base_cpu_q, base_mem_q;
	logic [hbp_pkg::AMT_W-1:0]     cpu_s1, mem_s1;
	logic [hbp_pkg::CLS_W-1:0]     cls_q, cls_d, step_q;
	logic [hbp_pkg::PROD_W-1:0]    scaled_cpu;

	hbp_pkg::cell_t                cells   [hbp_pkg::SEGMENTS];
	hbp_pkg::cell_ctl_t            ctl     [hbp_pkg::SEGMENTS];
	logic [hbp_pkg::SEGMENTS-1:0]  below, busy;

	hbp_pkg::cell_t                sel_cell, upd_cell;
	logic                          upd_emit;

	logic                          out_free, accept, commit, advance, flush_emit;
	logic                          rest_busy;

	logic                          bin_valid_q;
	hbp_pkg::cell_t                bin_q;
	logic [hbp_pkg::OCLS_W-1:0]    bin_class_q;
	logic                          last_q;

	assign cfg_ready  = 1'b1;
	assign item_stall = state_q != ST_IDLE;
	assign accept     = item_valid && !item_stall;
	assign out_free   = !bin_valid_q || !bin_stall;
	assign scaled_cpu = hbp_pkg::PROD_W'(cpu_s1) * hbp_pkg::PROD_W'(hbp_pkg::SEGMENTS);

	// Registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= {hbp_pkg::AMT_W{1'b1}};
			base_cpu_q <= '0;
			base_mem_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hbp_pkg::REG_LIMIT:    limit_q    <= cfg_data;
				hbp_pkg::REG_BASE_CPU: base_cpu_q <= cfg_data;
				hbp_pkg::REG_BASE_MEM: base_mem_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The row of class cells.
	for (genvar i = 0; i < hbp_pkg::SEGMENTS; i++) begin : g_cell
		hbp_pkg::cell_t nb;
		if (i == hbp_pkg::SEGMENTS - 1) begin : g_tail
			assign nb = '0;
		end else begin : g_mid
			assign nb = cells[i+1];
		end
		assign ctl[i].shift = advance;
		assign ctl[i].load  = commit && (cls_q == hbp_pkg::CLS_W'(i));
		assign busy[i]      = cells[i].count != '0;

		hbp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[i]),
			.load_data  (upd_cell),
			.neighbor   (nb),
			.weight     (hbp_pkg::WGT_W'(i + 1)),
			.limit      (limit_q),
			.scaled_cpu (scaled_cpu),
			.state      (cells[i]),
			.below      (below[i])
		);
	end

	// First class whose bound lies above the scaled request, else the last class.
	always_comb begin
		cls_d = hbp_pkg::CLS_W'(hbp_pkg::SEGMENTS - 1);
		for (int i = hbp_pkg::SEGMENTS - 1; i >= 0; i--) begin
			if (below[i]) begin
				cls_d = hbp_pkg::CLS_W'(i);
			end
		end
	end

	assign sel_cell = cells[cls_q];

	hbp_update u_update (
		.cur      (sel_cell),
		.cls      (cls_q),
		.cpu      (cpu_s1),
		.mem      (mem_s1),
		.limit    (limit_q),
		.base_cpu (base_cpu_q),
		.base_mem (base_mem_q),
		.next     (upd_cell),
		.emit     (upd_emit)
	);

	// During a flush the head cell holds the class numbered by step_q.
	assign rest_busy  = |busy[hbp_pkg::SEGMENTS-1:1];
	assign flush_emit = state_q == ST_FLUSH && busy[0] && out_free;
	assign advance    = state_q == ST_FLUSH && (!busy[0] || out_free);
	assign commit     = state_q == ST_UPDATE && (!upd_emit || out_free);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (command == hbp_pkg::CMD_FLUSH) ? ST_FLUSH : ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (advance && step_q == hbp_pkg::CLS_W'(hbp_pkg::SEGMENTS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (advance) begin
				step_q <= step_q + hbp_pkg::CLS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_s1 <= cpu_amount;
			mem_s1 <= memory_amount;
		end
		if (state_q == ST_CLASSIFY) begin
			cls_q <= cls_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= 1'b0;
		end else if (out_free) begin
			bin_valid_q <= flush_emit || (commit && upd_emit);
		end
	end

	always_ff @(posedge clk) begin
		if (flush_emit) begin
			bin_q       <= cells[0];
			bin_class_q <= hbp_pkg::OCLS_W'(step_q);
			last_q      <= !rest_busy;
		end else if (commit && upd_emit) begin
			bin_q       <= sel_cell;
			bin_class_q <= hbp_pkg::OCLS_W'(cls_q);
			last_q      <= 1'b1;
		end
	end

	assign bin_valid   = bin_valid_q;
	assign bin_cpu     = bin_q.cpu;
	assign bin_memory  = bin_q.mem;
	assign bin_items   = bin_q.count;
	assign bin_class   = bin_class_q;
	assign last_of_run = last_q;

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && advance && step_q == hbp_pkg::CLS_W'(hbp_pkg::SEGMENTS - 1))
		|=> (busy == '0))
		else $error("classes not empty after flush");

	a_items_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid_q |-> (bin_q.count != '0))
		else $error("empty bin emitted");

	a_items_cap: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid_q |-> ((hbp_pkg::OCLS_W + 1)'(bin_q.count) + (hbp_pkg::OCLS_W + 1)'(bin_class_q)
		                 <= (hbp_pkg::OCLS_W + 1)'(hbp_pkg::SEGMENTS)))
		else $error("bin holds more items than its class allows");

	a_update_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> ($past(state_q) == ST_CLASSIFY || $past(state_q) == ST_UPDATE))
		else $error("update entered without classification");

	a_cells_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_CLASSIFY) |=> ($stable(busy)))
		else $error("class state changed outside update or flush");

endmodule
